### design/b32d_pkg.sv
// Shared types, codes and character tables for the base32 stream decoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package b32d_pkg;

    localparam logic ALPHA_CROCKFORD = 1'b0;
    localparam logic ALPHA_RFC4648   = 1'b1;

    localparam logic REG_ALPHABET  = 1'b0;
    localparam logic REG_CASE_FOLD = 1'b1;

    localparam int CF_UPPER_BIT = 0;
    localparam int CF_LOWER_BIT = 1;

    localparam int CFG_DATA_W = 2;
    localparam int MAX_BYTES  = 5;
    localparam int ACC_W      = 8 * MAX_BYTES;

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [4:0] value;
    } sym_t;

    typedef struct packed {
        logic [ACC_W-1:0] data;
        logic [2:0]       count;
        logic             err;
        logic             last;
    } rec_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic [1:0] fold);
        logic [7:0] r;
        r = c;
        if (fold[CF_UPPER_BIT]) begin
            if (c inside {["a":"z"]}) begin
                r = c - 8'd32;
            end
        end else if (fold[CF_LOWER_BIT]) begin
            if (c inside {["A":"Z"]}) begin
                r = c + 8'd32;
            end
        end
        return r;
    endfunction

    // Returns {bad, value}.
    function automatic logic [5:0] crockford_value(input logic [7:0] c);
        logic [5:0] r;
        r = 6'h20;
        if (c inside {["0":"9"]}) begin
            r = {2'b00, c[3:0]};
        end else begin
            case (c)
                "O": r = 6'd0;
                "I": r = 6'd1;
                "L": r = 6'd1;
                "A": r = 6'd10;
                "B": r = 6'd11;
                "C": r = 6'd12;
                "D": r = 6'd13;
                "E": r = 6'd14;
                "F": r = 6'd15;
                "G": r = 6'd16;
                "H": r = 6'd17;
                "J": r = 6'd18;
                "K": r = 6'd19;
                "M": r = 6'd20;
                "N": r = 6'd21;
                "P": r = 6'd22;
                "Q": r = 6'd23;
                "R": r = 6'd24;
                "S": r = 6'd25;
                "T": r = 6'd26;
                "V": r = 6'd27;
                "W": r = 6'd28;
                "X": r = 6'd29;
                "Y": r = 6'd30;
                "Z": r = 6'd31;
                default: r = 6'h20;
            endcase
        end
        return r;
    endfunction

    // Returns {bad, value}.
    function automatic logic [5:0] rfc_value(input logic [7:0] c);
        logic [5:0] r;
        r = 6'h20;
        if (c inside {["A":"Z"]}) begin
            r = {1'b0, 5'(c - 8'h41)};
        end else if (c inside {["2":"7"]}) begin
            r = {1'b0, 5'(c - 8'd24)};
        end
        return r;
    endfunction

    // Bytes carried by a group with the given number of data characters.
    function automatic logic [2:0] byte_count(input logic [3:0] cnt);
        logic [2:0] r;
        case (cnt)
            4'd2:    r = 3'd1;
            4'd4:    r = 3'd2;
            4'd5:    r = 3'd3;
            4'd7:    r = 3'd4;
            4'd8:    r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/b32d_classify.sv
// Character classifier: case fold, then alphabet lookup or padding detect.
// Depends on b32d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32d_classify (
    input  wire logic [7:0] in_char,
    input  wire logic       alphabet_select,
    input  wire logic [1:0] case_fold,
    output b32d_pkg::sym_t  sym
);
    import b32d_pkg::*;

    logic [7:0] folded;
    logic [5:0] lookup;

    always_comb begin
        folded = fold_char(in_char, case_fold);
        lookup = (alphabet_select == ALPHA_RFC4648) ? rfc_value(folded)
                                                    : crockford_value(folded);
        sym.pad   = (folded == "=");
        sym.bad   = !sym.pad && lookup[5];
        sym.value = lookup[4:0];
    end

endmodule

`default_nettype wire

### design/b32d_group.sv
// Group assembler: per-character state update and one record per error-free group
// or per message, held in a single record slot. Depends on b32d_pkg, b32d_classify.
`timescale 1ns / 1ps
`default_nettype none

module b32d_group (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       alphabet_select,
    input  wire logic [1:0] case_fold,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    output logic            slot_valid,
    output b32d_pkg::rec_t  slot_rec,
    input  wire logic       slot_take
);
    import b32d_pkg::*;

    sym_t             sym;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_c;
    logic [2:0]       pos_reg, pos_next;
    logic [3:0]       cnt_reg, cnt_next, cnt_c;
    logic             pad_seen_reg, pad_seen_next, pad_c;
    logic             err_reg, err_next, err_c, err_f;
    logic             slot_valid_reg, slot_valid_next;
    rec_t             slot_rec_reg, slot_rec_next, rec;
    logic             accept, is_data, complete, cnt_ok, emit;

    b32d_classify u_classify (
        .in_char         (s_tdata),
        .alphabet_select (alphabet_select),
        .case_fold       (case_fold),
        .sym             (sym)
    );

    assign s_tready   = !slot_valid_reg || slot_take;
    assign accept     = s_tvalid && s_tready;
    assign slot_valid = slot_valid_reg;
    assign slot_rec   = slot_rec_reg;

    always_comb begin
        is_data  = !sym.bad && !sym.pad;
        err_c    = err_reg || sym.bad || (is_data && pad_seen_reg);
        pad_c    = pad_seen_reg || sym.pad;
        cnt_c    = cnt_reg + {3'b000, is_data};
        acc_c    = {acc_reg[ACC_W-6:0], is_data ? sym.value : 5'd0};
        complete = (pos_reg == 3'd7);
        cnt_ok   = cnt_c inside {4'd2, 4'd4, 4'd5, 4'd7, 4'd8};
        err_f    = err_c || (complete ? !cnt_ok : s_tlast);
        emit     = accept && (s_tlast || (complete && !err_f));

        if (err_f) begin
            rec.data  = '0;
            rec.count = 3'd1;
            rec.err   = 1'b1;
            rec.last  = 1'b1;
        end else begin
            rec.data  = acc_c;
            rec.count = byte_count(cnt_c);
            rec.err   = 1'b0;
            rec.last  = s_tlast;
        end

        acc_next      = acc_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        pad_seen_next = pad_seen_reg;
        err_next      = err_reg;
        if (accept) begin
            if (s_tlast) begin
                acc_next      = '0;
                pos_next      = 3'd0;
                cnt_next      = 4'd0;
                pad_seen_next = 1'b0;
                err_next      = 1'b0;
            end else begin
                acc_next      = complete ? '0 : acc_c;
                cnt_next      = complete ? 4'd0 : cnt_c;
                pos_next      = pos_reg + 3'd1;
                pad_seen_next = pad_c;
                err_next      = err_f;
            end
        end

        slot_valid_next = emit || (slot_valid_reg && !slot_take);
        slot_rec_next   = emit ? rec : slot_rec_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg        <= '0;
            pos_reg        <= 3'd0;
            cnt_reg        <= 4'd0;
            pad_seen_reg   <= 1'b0;
            err_reg        <= 1'b0;
            slot_valid_reg <= 1'b0;
        end else begin
            acc_reg        <= acc_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            pad_seen_reg   <= pad_seen_next;
            err_reg        <= err_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_rec_reg <= slot_rec_next;
    end

`ifndef NO_ASSERTIONS
    a_take_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_take |-> slot_valid_reg)
        else $error("record taken from an empty slot");

    a_eom_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> pos_reg == 3'd0 && !err_reg && !pad_seen_reg)
        else $error("state not cleared after end of message");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= {1'b0, pos_reg})
        else $error("data count exceeds group position");
`endif

endmodule

`default_nettype wire

### design/b32d_out.sv
// Output serializer: takes one record from the slot and sends its bytes
// one item per cycle while m_tready is high. Depends on b32d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b32d_out (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           slot_valid,
    input  wire b32d_pkg::rec_t slot_rec,
    output logic                slot_take,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);
    import b32d_pkg::*;

    logic       ser_valid_reg, ser_valid_next;
    rec_t       ser_rec_reg, ser_rec_next;
    logic [2:0] idx_reg, idx_next;
    logic       at_end, done;

    always_comb begin
        at_end    = (idx_reg == ser_rec_reg.count - 3'd1);
        done      = ser_valid_reg && m_tready && at_end;
        slot_take = slot_valid && (!ser_valid_reg || done);

        ser_valid_next = slot_take || (ser_valid_reg && !done);
        ser_rec_next   = slot_take ? slot_rec : ser_rec_reg;
        if (slot_take) begin
            idx_next = 3'd0;
        end else if (ser_valid_reg && m_tready) begin
            idx_next = idx_reg + 3'd1;
        end else begin
            idx_next = idx_reg;
        end

        case (idx_reg)
            3'd0:    m_tdata = ser_rec_reg.data[39:32];
            3'd1:    m_tdata = ser_rec_reg.data[31:24];
            3'd2:    m_tdata = ser_rec_reg.data[23:16];
            3'd3:    m_tdata = ser_rec_reg.data[15:8];
            3'd4:    m_tdata = ser_rec_reg.data[7:0];
            default: m_tdata = 8'd0;
        endcase
        m_tvalid = ser_valid_reg;
        m_tuser  = ser_rec_reg.err;
        m_tlast  = ser_rec_reg.last && at_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ser_rec_reg <= ser_rec_next;
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> idx_reg < ser_rec_reg.count)
        else $error("byte index beyond record length");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg && ser_rec_reg.err |-> ser_rec_reg.count == 3'd1 && ser_rec_reg.last)
        else $error("error record is not a single final item");

    a_take_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_take |=> ser_valid_reg && idx_reg == 3'd0)
        else $error("new record did not start at its first byte");
`endif

endmodule

`default_nettype wire

### design/base32_stream_decoder_core.sv
// Top level of the base32 stream decoder: configuration registers and the
// group assembler and output serializer. Depends on b32d_pkg, b32d_group, b32d_out.
//
// The decoder takes one character per cycle and returns decoded bytes one per cycle
// while m_tready is high. The group assembler updates its state in the cycle an item
// is taken; each error-free group of eight characters, and each end of message,
// leaves one record of one to five bytes in a single slot, which the serializer
// drains. The input stalls only while that slot is full and the serializer is still
// sending the previous record, so with an open output the sustained rate is one
// character per cycle, and a group's bytes pass through that slot and the serializer
// register. A message found invalid ends in one item with the error flag and last
// set; bytes already sent for that message must be discarded.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_decoder_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic                            cfg_index,
    input  wire logic [b32d_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // in_char
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // out_byte
    output logic                                 m_tuser,   // error_flag
    output logic                                 m_tlast
);
    import b32d_pkg::*;

    logic       alphabet_reg, alphabet_next;
    logic [1:0] fold_reg, fold_next;
    logic       slot_valid, slot_take;
    rec_t       slot_rec;

    always_comb begin
        alphabet_next = alphabet_reg;
        fold_next     = fold_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ALPHABET:  alphabet_next = cfg_wdata[0];
                REG_CASE_FOLD: fold_next     = cfg_wdata[1:0];
                default:       alphabet_next = alphabet_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alphabet_reg <= ALPHA_CROCKFORD;
            fold_reg     <= 2'd0;
        end else begin
            alphabet_reg <= alphabet_next;
            fold_reg     <= fold_next;
        end
    end

    b32d_group u_group (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .alphabet_select (alphabet_reg),
        .case_fold       (fold_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .slot_valid      (slot_valid),
        .slot_rec        (slot_rec),
        .slot_take       (slot_take)
    );

    b32d_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .slot_valid (slot_valid),
        .slot_rec   (slot_rec),
        .slot_take  (slot_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
